// ===== rtl/core/packet_rule_classifier_macros.svh =====
// Assertion macros for the packet rule classifier.
// Used by the top level; needs clk_i and rst_ni in scope.
`ifndef PACKET_RULE_CLASSIFIER_MACROS_SVH
`define PACKET_RULE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/prc_pkg.sv =====
// Shared types, codes and constants of the packet rule classifier.
// No dependencies.
package prc_pkg;

  localparam int unsigned RuleSlotsDefault = 16;
  localparam int unsigned RuleWords        = 8;
  localparam int unsigned CfgWidth         = 32;
  localparam logic [31:0] LoopbackReset    = 32'h7F00_0001;
  localparam logic [15:0] EtherTypeIpv4    = 16'h0800;
  localparam logic [3:0]  IpVersion4       = 4'd4;
  localparam logic [7:0]  ProtoIcmp        = 8'd1;
  localparam logic [7:0]  ProtoTcp         = 8'd6;
  localparam logic [7:0]  ProtoUdp         = 8'd17;

  localparam logic [1:0] CfgRuleCount = 2'd0;
  localparam logic [1:0] CfgListenEn  = 2'd1;
  localparam logic [1:0] CfgListenPrt = 2'd2;
  localparam logic [1:0] CfgLoopback  = 2'd3;

  localparam logic       CmdRuleWord = 1'b0;
  localparam logic       CmdHeader   = 1'b1;
  localparam logic [2:0] HdrLastWord = 3'd3;

  localparam logic [2:0] ClsUdp   = 3'd0;
  localparam logic [2:0] ClsTcp   = 3'd1;
  localparam logic [2:0] ClsIcmp  = 3'd2;
  localparam logic [2:0] ClsOther = 3'd3;
  localparam logic [2:0] ClsRaw   = 3'd4;

  localparam logic [1:0] ActLog     = 2'd0;
  localparam logic [1:0] ActDump    = 2'd1;
  localparam logic [1:0] ActLogDump = 2'd2;
  localparam logic [1:0] ActIgnore  = 2'd3;

  localparam logic [1:0] KindMatch  = 2'd0;
  localparam logic [1:0] KindListen = 2'd1;
  localparam logic [1:0] KindDone   = 2'd2;

  typedef struct packed {
    logic        command;
    logic [3:0]  rule_slot;
    logic [2:0]  word_index;
    logic [63:0] data;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] matched_slot;
    logic [1:0] action;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic flags_clear;
    logic ptr_clear;
    logic pass_raw;
    logic rd_cur;
    logic rd_next;
    logic emit_listen;
    logic emit_match;
    logic emit_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_req;
    logic ipv4;
    logic listen;
    logic hit;
    logic ignore;
    logic ptr_end;
    logic next_end;
    logic raw_pass;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/prc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/prc_ctrl.sv =====
// Scan sequencer of the packet rule classifier.
// Depends on prc_pkg; drives commands into prc_dp.
module prc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  prc_pkg::dp_status_t status_i,
  output prc_pkg::ctrl_cmd_t  cmd_o
);
  import prc_pkg::*;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StStart = 5'b00010,
    StIssue = 5'b00100,
    StEval  = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i && status_i.start_req) begin
          state_d = StStart;
        end
      end
      StStart: begin
        cmd_o.flags_clear = 1'b1;
        if (!status_i.ipv4) begin
          state_d = StDone;
        end else if (!status_i.listen || status_i.out_free) begin
          cmd_o.emit_listen = status_i.listen;
          cmd_o.ptr_clear   = 1'b1;
          state_d           = StIssue;
        end
      end
      StIssue: begin
        if (!status_i.ptr_end) begin
          cmd_o.rd_cur = 1'b1;
          state_d      = StEval;
        end else if (status_i.raw_pass) begin
          state_d = StDone;
        end else begin
          cmd_o.pass_raw  = 1'b1;
          cmd_o.ptr_clear = 1'b1;
        end
      end
      StEval: begin
        if (!status_i.hit || status_i.out_free) begin
          cmd_o.emit_match = status_i.hit;
          if ((status_i.hit && status_i.ignore) || status_i.next_end) begin
            // end of this pass
            if (status_i.raw_pass) begin
              state_d = StDone;
            end else begin
              cmd_o.pass_raw  = 1'b1;
              cmd_o.ptr_clear = 1'b1;
              state_d         = StIssue;
            end
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.emit_done = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/prc_dp.sv =====
// Datapath of the packet rule classifier: rule RAM banks, header and
// configuration registers, rule check logic and output register.
// Depends on prc_pkg and prc_ram.
module prc_dp #(
  parameter int unsigned RuleSlots = prc_pkg::RuleSlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [prc_pkg::CfgWidth-1:0]  cfg_wdata_i,
  input  logic                          in_fire_i,
  input  prc_pkg::in_item_t             in_item_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output prc_pkg::out_item_t            out_item_o,
  input  prc_pkg::ctrl_cmd_t            cmd_i,
  output prc_pkg::dp_status_t           status_o
);
  import prc_pkg::*;

  localparam int unsigned AW = $clog2(RuleSlots);
  localparam int unsigned PW = $clog2(RuleSlots + 1);

  // configuration
  logic [4:0]  rule_count_q;
  logic        listen_en_q;
  logic [15:0] listen_port_q;
  logic [31:0] loopback_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_count_q  <= '0;
      listen_en_q   <= 1'b0;
      listen_port_q <= '0;
      loopback_q    <= LoopbackReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgRuleCount: rule_count_q  <= cfg_wdata_i[4:0];
        CfgListenEn:  listen_en_q   <= cfg_wdata_i[0];
        CfgListenPrt: listen_port_q <= cfg_wdata_i[15:0];
        CfgLoopback:  loopback_q    <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // header words
  logic [63:0] h0_q, h1_q, h2_q, h3_q;
  logic        hdr_fire, rule_fire;

  assign hdr_fire  = in_fire_i && (in_item_i.command == CmdHeader);
  assign rule_fire = in_fire_i && (in_item_i.command == CmdRuleWord) &&
                     (32'(in_item_i.rule_slot) < RuleSlots);

  always_ff @(posedge clk_i) begin
    if (hdr_fire) begin
      case (in_item_i.word_index)
        3'd0:        h0_q <= in_item_i.data;
        3'd1:        h1_q <= in_item_i.data;
        3'd2:        h2_q <= in_item_i.data;
        HdrLastWord: h3_q <= in_item_i.data;
        default: ;
      endcase
    end
  end

  logic [47:0] dmac, smac;
  logic [31:0] sip, dip;
  logic [15:0] sport, dport;
  logic [7:0]  proto, tflags, itype, icode;
  logic [2:0]  pkt_cls;

  assign dmac   = h0_q[47:0];
  assign smac   = h1_q[47:0];
  assign proto  = h1_q[55:48];
  assign sip    = h2_q[31:0];
  assign dip    = h2_q[63:32];
  assign sport  = h3_q[15:0];
  assign dport  = h3_q[31:16];
  assign tflags = h3_q[39:32];
  assign itype  = h3_q[47:40];
  assign icode  = h3_q[55:48];

  always_comb begin
    if (proto == ProtoUdp) begin
      pkt_cls = ClsUdp;
    end else if (proto == ProtoTcp) begin
      pkt_cls = ClsTcp;
    end else if (proto == ProtoIcmp) begin
      pkt_cls = ClsIcmp;
    end else begin
      pkt_cls = ClsOther;
    end
  end

  // scan pointer, pass and suppression flags
  logic [PW-1:0] ptr_q, n_eff;
  logic          raw_q, logged_q, dumped_q;

  always_comb begin
    if (32'(rule_count_q) >= RuleSlots) begin
      n_eff = PW'(RuleSlots);
    end else begin
      n_eff = PW'(rule_count_q);
    end
  end

  // rule RAM: one bank per rule word, all read at the same slot
  logic [63:0]   rw [RuleWords];
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  assign rd_en   = cmd_i.rd_cur || cmd_i.rd_next;
  assign rd_addr = cmd_i.rd_next ? AW'(ptr_q + 1'b1) : AW'(ptr_q);

  for (genvar b = 0; b < RuleWords; b++) begin : g_bank
    prc_ram #(
      .Width(64),
      .Depth(RuleSlots)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (rule_fire && (in_item_i.word_index == 3'(b))),
      .waddr_i(AW'(in_item_i.rule_slot)),
      .wdata_i(in_item_i.data),
      .re_i   (rd_en),
      .raddr_i(rd_addr),
      .rdata_o(rw[b])
    );
  end

  // rule checks
  logic [2:0] cls;
  logic [1:0] act;
  logic       hit;
  logic [7:0] on_m, off_m;

  assign cls   = raw_q ? ClsRaw : pkt_cls;
  assign act   = rw[0][4:3];
  assign on_m  = rw[0][28:21];
  assign off_m = rw[0][36:29];

  always_comb begin
    hit = (rw[0][2:0] == cls);
    if (act == ActLog && logged_q) hit = 1'b0;
    if (act == ActDump && dumped_q) hit = 1'b0;
    if (act == ActLogDump && logged_q && dumped_q) hit = 1'b0;
    if (rw[0][5] && rw[1][47:0] != smac) hit = 1'b0;
    if (rw[0][6] && rw[2][47:0] != dmac) hit = 1'b0;
    if (rw[0][7] && rw[3][47:0] == smac) hit = 1'b0;
    if (rw[0][8] && rw[4][47:0] == dmac) hit = 1'b0;
    if (cls != ClsRaw) begin
      if (rw[0][9]  && rw[5][31:0]  != sip) hit = 1'b0;
      if (rw[0][10] && rw[5][63:32] != dip) hit = 1'b0;
      if (rw[0][11] && rw[6][31:0]  == sip) hit = 1'b0;
      if (rw[0][12] && rw[6][63:32] == dip) hit = 1'b0;
    end
    if (cls == ClsUdp || cls == ClsTcp) begin
      if (rw[0][13] && rw[1][63:48] == sport) hit = 1'b0;
      if (rw[0][14] && rw[2][63:48] == dport) hit = 1'b0;
      if (rw[0][15] && (sport < rw[7][15:0] || sport > rw[7][31:16])) hit = 1'b0;
      if (rw[0][16] && (dport < rw[7][47:32] || dport > rw[7][63:48])) hit = 1'b0;
    end
    if (cls == ClsTcp) begin
      if (rw[0][17] && (tflags & on_m) != on_m) hit = 1'b0;
      if (rw[0][18] && (~tflags & off_m) != off_m) hit = 1'b0;
    end
    if (cls == ClsIcmp) begin
      if (rw[0][19] && rw[0][44:37] != itype) hit = 1'b0;
      if (rw[0][20] && rw[0][52:45] != icode) hit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      raw_q    <= 1'b0;
      logged_q <= 1'b0;
      dumped_q <= 1'b0;
    end else begin
      if (cmd_i.ptr_clear) begin
        ptr_q <= '0;
      end else if (cmd_i.rd_next) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.flags_clear) begin
        raw_q    <= 1'b0;
        logged_q <= 1'b0;
        dumped_q <= 1'b0;
      end else begin
        if (cmd_i.pass_raw) begin
          raw_q <= 1'b1;
        end
        if (cmd_i.emit_match) begin
          if (act == ActLog || act == ActLogDump) logged_q <= 1'b1;
          if (act == ActDump || act == ActLogDump) dumped_q <= 1'b1;
        end
      end
    end
  end

  // output register
  logic      out_valid_q;
  out_item_t out_q;
  logic      out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_listen || cmd_i.emit_match || cmd_i.emit_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_match) begin
      out_q <= '{kind: KindMatch, matched_slot: 4'(ptr_q), action: act, last: 1'b0};
    end else if (cmd_i.emit_listen) begin
      out_q <= '{kind: KindListen, matched_slot: '0, action: '0, last: 1'b0};
    end else if (cmd_i.emit_done) begin
      out_q <= '{kind: KindDone, matched_slot: '0, action: '0, last: 1'b1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status_o.start_req = (in_item_i.command == CmdHeader) &&
                              (in_item_i.word_index == HdrLastWord);
  assign status_o.ipv4      = (h0_q[63:48] == EtherTypeIpv4) && (h1_q[59:56] == IpVersion4);
  assign status_o.listen    = (pkt_cls == ClsUdp) && listen_en_q && (dport == listen_port_q) &&
                              (sip == loopback_q) && (dip == loopback_q) &&
                              (dmac == '0) && (smac == '0);
  assign status_o.hit       = hit;
  assign status_o.ignore    = (act == ActIgnore);
  assign status_o.ptr_end   = (ptr_q >= n_eff);
  assign status_o.next_end  = ({1'b0, ptr_q} + 1'b1) >= {1'b0, n_eff};
  assign status_o.raw_pass  = raw_q;
  assign status_o.out_free  = out_free;

endmodule

// ===== rtl/core/packet_rule_classifier.sv =====
// Packet rule classifier, top level.
// Channels: in_valid_i/in_ready_o carry in_item_i; command 0 writes one
//   word of a rule slot, command 1 writes a header word, and header word 3
//   starts a scan. out_valid_o/out_ready_i carry out_item_o.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
//   (rule count, listen enable, listen port, loopback address) at once.
// Rule words and header words 0..2 are taken only while no scan runs. A starting
//   header word blocks input until the scan ends: a start state decodes the
//   header, then each of the two passes (packet class, then raw) starts in an
//   issue state and reads every slot in use, one RAM read per cycle while no
//   match waits for the output register; a done state then loads done. An ignore
//   match cuts its pass short. A listen result is loaded from the start state.
// A non-IPv4 frame gives only the done result, with no scan.
// Results go through one output register: while the receiver stalls, the
//   scan holds at the next result; after done is loaded, input is open again.
// Reset clears control state and configuration (loopback 127.0.0.1);
//   rule and header stores hold nothing until written.
// Depends on prc_pkg, prc_ctrl, prc_dp, prc_ram and the macro header.
`include "packet_rule_classifier_macros.svh"

module packet_rule_classifier #(
  parameter int unsigned RuleSlots = prc_pkg::RuleSlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [prc_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  prc_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output prc_pkg::out_item_t           out_item_o
);
  import prc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  prc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  prc_dp #(
    .RuleSlots(RuleSlots)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_fire_i  (in_valid_i && in_ready_o),
    .in_item_i  (in_item_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

  `PRC_ASSERT_NOW(a_one_emit, 1'b1, $onehot0({cmd.emit_listen, cmd.emit_match, cmd.emit_done}), "two results loaded at once")
  `PRC_ASSERT_NOW(a_emit_free, cmd.emit_listen || cmd.emit_match || cmd.emit_done, status.out_free, "result overwrites a waiting one")
  `PRC_ASSERT_NOW(a_no_read_in_idle, cmd.rd_cur || cmd.rd_next, !in_ready_o, "rule read while taking input")
  `PRC_ASSERT_NEXT(a_done_last, cmd.emit_done, out_valid_o && out_item_o.last, "done result lacks last")

endmodule
